// File: rtl/core/egbw_pkg.sv
// Shared types and constants of the Exp-Golomb bit writer.
`timescale 1ns / 1ps
package egbw_pkg;

   localparam int TYPE_W = 3;
   localparam int VALUE_W = 32;
   localparam int COUNT_IN_W = 6;
   localparam int BYTE_W = 8;
   localparam int CODE_W = 2 * VALUE_W + 1;
   localparam int REM_W = 7;
   localparam int EXP_W = VALUE_W + 1;
   localparam int LEN_W = 6;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_IDX_W = 1;
   localparam int QUEUE_CNT_W = 2;

   localparam logic [TYPE_W-1:0] TYPE_FIXED = 3'd0;
   localparam logic [TYPE_W-1:0] TYPE_UE = 3'd1;
   localparam logic [TYPE_W-1:0] TYPE_SE = 3'd2;
   localparam logic [TYPE_W-1:0] TYPE_ALIGN = 3'd3;
   localparam logic [TYPE_W-1:0] TYPE_TRAIL = 3'd4;

   localparam logic [COUNT_IN_W-1:0] MAX_FIXED_BITS = 6'd32;

   typedef enum logic [1:0] {
      KIND_BITS,
      KIND_ALIGN,
      KIND_TRAIL
   } kind_type;

   // One classified request: code is left aligned, the next bit to write in the MSB.
   typedef struct packed {
      kind_type kind;
      logic [CODE_W-1:0] code;
      logic [REM_W-1:0] count;
   } entry_type;

endpackage

// File: rtl/core/egbw_req_if.sv
// Request channel interface of the Exp-Golomb bit writer.
`timescale 1ns / 1ps
interface egbw_req_if;
   import egbw_pkg::*;

   logic valid;
   logic ready;
   logic [TYPE_W-1:0] req_type;
   logic [VALUE_W-1:0] value;
   logic [COUNT_IN_W-1:0] bit_count;
   logic fill_bit;

   modport source (output valid, req_type, value, bit_count, fill_bit, input ready);
   modport sink (input valid, req_type, value, bit_count, fill_bit, output ready);
endinterface

// File: rtl/core/egbw_rsp_if.sv
// Byte output channel interface of the Exp-Golomb bit writer.
`timescale 1ns / 1ps
interface egbw_rsp_if;
   import egbw_pkg::*;

   logic valid;
   logic ready;
   logic [BYTE_W-1:0] out_byte;
   logic last;

   modport source (output valid, out_byte, last, input ready);
   modport sink (input valid, out_byte, last, output ready);
endinterface

// File: rtl/core/exp_golomb_bit_writer_top.sv
// Top level of the Exp-Golomb bit writer.
//
// Requests arrive on req_bus: fixed bits, ue(v), se(v), byte align with a fill
// bit, or RBSP trailing bits. Bits are packed MSB first; each completed byte
// leaves on rsp_bus as one beat, and the last byte completed by a request
// carries last. A request that completes no byte gives no beat; its bits stay
// in the partial byte for later requests.
// The front end takes one request per cycle while its register is free or the
// queue has room, registers it once, and pushes the code word formed from that
// register when the queue has room. The back end writes up to the free bits of
// the partial byte per cycle unless the output register holds a stalled beat,
// and takes the next queue entry only when all bits of the current one are
// written. A byte appears on rsp_bus in the cycle after the back end completes
// it, so the first beat of a request passes the front-end register, a queue
// slot and the output register. A two-entry queue sits between the ends. When
// the receiver stalls, the output register holds its beat, the back end stops,
// and the queue and front end fill before req_bus.ready falls. Reset empties
// the pipeline and clears the partial byte and bit position to zero.
`timescale 1ns / 1ps
module exp_golomb_bit_writer_top (
   input logic clock,
   input logic reset,
   egbw_req_if.sink req_bus,
   egbw_rsp_if.source rsp_bus
);
   import egbw_pkg::*;

   logic push_valid;
   logic push_ready;
   entry_type push_entry;
   logic head_valid;
   logic pop;
   entry_type head_entry;

   egbw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_bus.valid),
      .in_ready   (req_bus.ready),
      .in_type    (req_bus.req_type),
      .in_value   (req_bus.value),
      .in_count   (req_bus.bit_count),
      .in_fill    (req_bus.fill_bit),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   egbw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .head_valid (head_valid),
      .pop        (pop),
      .head_entry (head_entry)
   );

   egbw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .out_valid  (rsp_bus.valid),
      .out_ready  (rsp_bus.ready),
      .out_byte   (rsp_bus.out_byte),
      .out_last   (rsp_bus.last)
   );

endmodule

// File: rtl/core/egbw_front.sv
// Front end: accepts requests, maps them to left-aligned code words and lengths.
`timescale 1ns / 1ps
module egbw_front (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic [egbw_pkg::TYPE_W-1:0] in_type,
   input  logic [egbw_pkg::VALUE_W-1:0] in_value,
   input  logic [egbw_pkg::COUNT_IN_W-1:0] in_count,
   input  logic in_fill,
   output logic push_valid,
   input  logic push_ready,
   output egbw_pkg::entry_type push_entry
);
   import egbw_pkg::*;

   logic s1_valid_ff, s1_valid_in;
   kind_type s1_kind_ff, s1_kind_in;
   logic s1_exp_ff, s1_exp_in;
   logic [EXP_W-1:0] s1_r_ff, s1_r_in;
   logic [COUNT_IN_W-1:0] s1_cnt_ff, s1_cnt_in;
   logic s1_fill_ff, s1_fill_in;

   logic advance;
   logic keep;
   logic [VALUE_W-1:0] neg_value;
   logic [LEN_W-1:0] bit_len;
   logic [REM_W-1:0] code_len;
   logic [REM_W-1:0] shift_amt;
   logic [CODE_W-1:0] right_code;

   assign advance = !s1_valid_ff || push_ready;
   assign in_ready = advance;
   assign neg_value = VALUE_W'(0) - in_value;

   always_comb begin
      keep = 1'b0;
      s1_kind_in = KIND_BITS;
      s1_exp_in = 1'b0;
      s1_r_in = {1'b0, in_value};
      s1_cnt_in = (in_count > MAX_FIXED_BITS) ? MAX_FIXED_BITS : in_count;
      s1_fill_in = in_fill;
      case (in_type)
         TYPE_FIXED: begin
            keep = (in_count != '0);
         end
         TYPE_UE: begin
            keep = 1'b1;
            s1_exp_in = 1'b1;
            s1_r_in = {1'b0, in_value} + EXP_W'(1);
         end
         TYPE_SE: begin
            keep = 1'b1;
            s1_exp_in = 1'b1;
            if ((in_value != '0) && !in_value[VALUE_W-1]) begin
               s1_r_in = {1'b0, in_value[VALUE_W-2:0], 1'b0};
            end else begin
               s1_r_in = {1'b0, neg_value[VALUE_W-2:0], 1'b1};
            end
         end
         TYPE_ALIGN: begin
            keep = 1'b1;
            s1_kind_in = KIND_ALIGN;
         end
         TYPE_TRAIL: begin
            keep = 1'b1;
            s1_kind_in = KIND_TRAIL;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
      s1_valid_in = advance ? (in_valid && keep) : s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (advance && in_valid) begin
         s1_kind_ff <= s1_kind_in;
         s1_exp_ff <= s1_exp_in;
         s1_r_ff <= s1_r_in;
         s1_cnt_ff <= s1_cnt_in;
         s1_fill_ff <= s1_fill_in;
      end
   end

   always_comb begin
      bit_len = '0;
      for (int i = 0; i < EXP_W; i++) begin
         if (s1_r_ff[i]) begin
            bit_len = LEN_W'(i + 1);
         end
      end
   end

   always_comb begin
      if (s1_exp_ff) begin
         code_len = {bit_len, 1'b0} - REM_W'(1);
      end else begin
         code_len = {1'b0, s1_cnt_ff};
      end
      shift_amt = REM_W'(CODE_W) - code_len;
      right_code = {{(CODE_W-EXP_W){1'b0}}, s1_r_ff};
      push_entry.kind = s1_kind_ff;
      push_entry.count = code_len;
      case (s1_kind_ff)
         KIND_ALIGN: push_entry.code = {CODE_W{s1_fill_ff}};
         KIND_TRAIL: push_entry.code = {1'b1, {(CODE_W-1){1'b0}}};
         default:    push_entry.code = right_code << shift_amt;
      endcase
   end

   assign push_valid = s1_valid_ff;

endmodule

// File: rtl/core/egbw_queue.sv
// Short queue of classified requests between the front and back ends.
`timescale 1ns / 1ps
module egbw_queue (
   input  logic clock,
   input  logic reset,
   input  logic push_valid,
   output logic push_ready,
   input  egbw_pkg::entry_type push_entry,
   output logic head_valid,
   input  logic pop,
   output egbw_pkg::entry_type head_entry
);
   import egbw_pkg::*;

   entry_type slot_ff [QUEUE_DEPTH];
   logic [QUEUE_IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic push_fire;
   logic pop_fire;

   assign push_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign push_fire = push_valid && push_ready;
   assign pop_fire = pop && head_valid;

   always_comb begin
      wr_ptr_in = push_fire ? wr_ptr_ff + QUEUE_IDX_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop_fire ? rd_ptr_ff + QUEUE_IDX_W'(1) : rd_ptr_ff;
      count_in = count_ff + QUEUE_CNT_W'(push_fire) - QUEUE_CNT_W'(pop_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push_fire) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: rtl/core/egbw_back.sv
// Back end: shifts code bits into the partial byte and emits each completed byte.
`timescale 1ns / 1ps
module egbw_back (
   input  logic clock,
   input  logic reset,
   input  logic head_valid,
   input  egbw_pkg::entry_type head_entry,
   output logic pop,
   output logic out_valid,
   input  logic out_ready,
   output logic [egbw_pkg::BYTE_W-1:0] out_byte,
   output logic out_last
);
   import egbw_pkg::*;

   logic busy_ff, busy_in;
   logic [CODE_W-1:0] work_buf_ff, work_buf_in;
   logic [REM_W-1:0] work_rem_ff, work_rem_in;
   logic [BYTE_W-1:0] partial_ff, partial_in;
   logic [2:0] pos_ff, pos_in;
   logic out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic out_last_ff, out_last_in;

   logic step_en;
   logic [CODE_W-1:0] src_buf;
   logic [REM_W-1:0] src_rem;
   logic [3:0] room;
   logic [3:0] take;
   logic [3:0] sum;
   logic [BYTE_W-1:0] mask;
   logic [BYTE_W-1:0] merged;
   logic [REM_W-1:0] rem_next;
   logic byte_done;

   assign room = 4'd8 - {1'b0, pos_ff};
   assign step_en = (busy_ff || head_valid) && (!out_valid_ff || out_ready);
   assign pop = step_en && !busy_ff;

   always_comb begin
      src_buf = head_entry.code;
      src_rem = head_entry.count;
      if (busy_ff) begin
         src_buf = work_buf_ff;
         src_rem = work_rem_ff;
      end else begin
         case (head_entry.kind)
            KIND_ALIGN: src_rem = (pos_ff == '0) ? '0 : {3'b000, room};
            KIND_TRAIL: src_rem = {3'b000, room};
            default:    src_rem = head_entry.count;
         endcase
      end
      take = (src_rem < {3'b000, room}) ? src_rem[3:0] : room;
      sum = {1'b0, pos_ff} + take;
      mask = (8'hFF >> pos_ff) & ~(8'hFF >> sum);
      merged = partial_ff | ((src_buf[CODE_W-1 -: BYTE_W] >> pos_ff) & mask);
      rem_next = src_rem - {3'b000, take};
      byte_done = (sum == 4'd8);
   end

   always_comb begin
      busy_in = busy_ff;
      work_buf_in = work_buf_ff;
      work_rem_in = work_rem_ff;
      partial_in = partial_ff;
      pos_in = pos_ff;
      out_valid_in = out_valid_ff && !out_ready;
      out_byte_in = out_byte_ff;
      out_last_in = out_last_ff;
      if (step_en) begin
         busy_in = (rem_next != '0);
         work_buf_in = src_buf << take;
         work_rem_in = rem_next;
         if (byte_done) begin
            partial_in = '0;
            pos_in = '0;
            out_valid_in = 1'b1;
            out_byte_in = merged;
            out_last_in = (rem_next < REM_W'(BYTE_W));
         end else begin
            partial_in = merged;
            pos_in = sum[2:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         partial_ff <= '0;
         pos_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         partial_ff <= partial_in;
         pos_ff <= pos_in;
         out_valid_ff <= out_valid_in;
      end
      work_buf_ff <= work_buf_in;
      work_rem_ff <= work_rem_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign out_valid = out_valid_ff;
   assign out_byte = out_byte_ff;
   assign out_last = out_last_ff;

   a_busy_has_bits: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (work_rem_ff != '0))
      else $error("Back end busy with no bits left.");

   a_partial_clean: assert property (@(posedge clock) disable iff (reset)
      (partial_ff & (8'hFF >> pos_ff)) == 8'h00)
      else $error("Unwritten bits of the partial byte are not zero.");

   a_pop_from_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> (head_valid && !busy_ff))
      else $error("Queue popped while empty or while an item is in progress.");

   a_byte_lands: assert property (@(posedge clock) disable iff (reset)
      (step_en && byte_done) |=> (out_valid_ff && (pos_ff == '0)))
      else $error("Completed byte not presented or position not cleared.");

endmodule

// File: verif/egbw_stream_checker.sv
// Checker that predicts the byte stream of the Exp-Golomb bit writer and compares every beat.
`timescale 1ns / 1ps
module egbw_stream_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic [egbw_pkg::TYPE_W-1:0] req_type,
   input logic [egbw_pkg::VALUE_W-1:0] req_value,
   input logic [egbw_pkg::COUNT_IN_W-1:0] req_bit_count,
   input logic req_fill_bit,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [egbw_pkg::BYTE_W-1:0] rsp_out_byte,
   input logic rsp_last,
   output int fail_count,
   output int bytes_pending
);
   import egbw_pkg::*;

   logic [BYTE_W-1:0] model_byte;
   logic [2:0] model_pos;
   logic [BYTE_W-1:0] want_byte_q[$];
   logic want_last_q[$];

   initial begin
      fail_count = 0;
      bytes_pending = 0;
      model_byte = '0;
      model_pos = '0;
   end

   task automatic shift_bit(input logic b);
      if (b) begin
         model_byte[3'd7 - model_pos] = 1'b1;
      end
      model_pos = model_pos + 3'd1;
      if (model_pos == 3'd0) begin
         want_byte_q.push_back(model_byte);
         want_last_q.push_back(1'b0);
         model_byte = '0;
      end
   endtask

   task automatic shift_bits(input logic [CODE_W-1:0] bits, input int n);
      for (int i = n - 1; i >= 0; i--) begin
         shift_bit(bits[i]);
      end
   endtask

   task automatic shift_ue(input logic [VALUE_W-1:0] v);
      logic [EXP_W-1:0] code;
      int len;
      code = {1'b0, v} + {{(EXP_W-1){1'b0}}, 1'b1};
      len = 0;
      for (int i = 0; i < EXP_W; i++) begin
         if (code[i]) begin
            len = i + 1;
         end
      end
      shift_bits({{(CODE_W-EXP_W){1'b0}}, code}, 2 * len - 1);
   endtask

   task automatic predict_bytes(input logic [TYPE_W-1:0] code_sel,
                                input logic [VALUE_W-1:0] v,
                                input logic [COUNT_IN_W-1:0] n,
                                input logic fill);
      int first;
      logic [VALUE_W-1:0] mapped;
      first = want_byte_q.size();
      case (code_sel)
         TYPE_FIXED: begin
            shift_bits({{(CODE_W-VALUE_W){1'b0}}, v},
                       (n > MAX_FIXED_BITS) ? int'(MAX_FIXED_BITS) : int'(n));
         end
         TYPE_UE: begin
            shift_ue(v);
         end
         TYPE_SE: begin
            // Positive values map to odd codes; zero, negatives and the wrap case to even ones.
            if (v != '0 && !v[VALUE_W-1]) begin
               mapped = (v << 1) - 32'd1;
            end else begin
               mapped = 32'd0 - (v << 1);
            end
            shift_ue(mapped);
         end
         TYPE_ALIGN: begin
            while (model_pos != 3'd0) begin
               shift_bit(fill);
            end
         end
         TYPE_TRAIL: begin
            shift_bit(1'b1);
            while (model_pos != 3'd0) begin
               shift_bit(1'b0);
            end
         end
         default: begin
         end
      endcase
      if (want_byte_q.size() > first) begin
         want_last_q[want_last_q.size() - 1] = 1'b1;
      end
   endtask

   always @(posedge clock) begin
      logic [BYTE_W-1:0] exp_byte;
      logic exp_last;
      if (reset) begin
         model_byte = '0;
         model_pos = '0;
         want_byte_q.delete();
         want_last_q.delete();
      end else begin
         if (req_valid && req_ready) begin
            predict_bytes(req_type, req_value, req_bit_count, req_fill_bit);
         end
         if (rsp_valid && rsp_ready) begin
            if (want_byte_q.size() == 0) begin
               $display("%0t ns: unexpected beat, expected none, actual byte %02h last %0b",
                        $time, rsp_out_byte, rsp_last);
               fail_count++;
            end else begin
               exp_byte = want_byte_q.pop_front();
               exp_last = want_last_q.pop_front();
               if (rsp_out_byte !== exp_byte) begin
                  $display("%0t ns: byte mismatch, expected %02h, actual %02h",
                           $time, exp_byte, rsp_out_byte);
                  fail_count++;
               end
               if (rsp_last !== exp_last) begin
                  $display("%0t ns: last mismatch, expected %0b, actual %0b",
                           $time, exp_last, rsp_last);
                  fail_count++;
               end
            end
         end
      end
      bytes_pending = want_byte_q.size();
   end

endmodule

// File: verif/tb_top.sv
// Testbench top of the Exp-Golomb bit writer: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
   import egbw_pkg::*;

   localparam int ITEM_TARGET = 80;
   localparam int IDLE_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 30;

   logic clock;
   logic reset;
   int fail_count;
   int bytes_pending;
   bit gaps_on;
   bit stalls_on;

   egbw_req_if req_bus ();
   egbw_rsp_if rsp_bus ();

   exp_golomb_bit_writer_top uut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   egbw_stream_checker stream_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_bus.valid),
      .req_ready(req_bus.ready),
      .req_type(req_bus.req_type),
      .req_value(req_bus.value),
      .req_bit_count(req_bus.bit_count),
      .req_fill_bit(req_bus.fill_bit),
      .rsp_valid(rsp_bus.valid),
      .rsp_ready(rsp_bus.ready),
      .rsp_out_byte(rsp_bus.out_byte),
      .rsp_last(rsp_bus.last),
      .fail_count(fail_count),
      .bytes_pending(bytes_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      int stall_left;
      int r;
      stall_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (reset || !stalls_on) begin
            rsp_bus.ready <= 1'b1;
            stall_left = 0;
         end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               rsp_bus.ready <= 1'b1;
            end else begin
               rsp_bus.ready <= 1'b0;
               stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 50);
            end
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!gaps_on || r < 55) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 15);
         1: return $urandom;
         2: return (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
         default: begin
            case ($urandom_range(0, 3))
               0: return 32'h0000_0000;
               1: return 32'hFFFF_FFFF;
               2: return 32'h7FFF_FFFF;
               default: return 32'h8000_0000;
            endcase
         end
      endcase
   endfunction

   // Returns at the rising edge at which the beat is taken.
   task automatic send_req(input logic [TYPE_W-1:0] code_sel, input logic [VALUE_W-1:0] v,
                           input logic [COUNT_IN_W-1:0] n, input logic fill);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.req_type <= code_sel;
      req_bus.value <= v;
      req_bus.bit_count <= n;
      req_bus.fill_bit <= fill;
      do @(negedge clock); while (!req_bus.ready);
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (bytes_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int accepted;
      int r;
      logic [TYPE_W-1:0] code_sel;
      logic [COUNT_IN_W-1:0] n;
      reset = 1'b1;
      gaps_on = 1'b1;
      stalls_on = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.req_type = '0;
      req_bus.value = '0;
      req_bus.bit_count = '0;
      req_bus.fill_bit = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_req(TYPE_FIXED, 32'hDEAD_BEEF, 6'd0, 1'b1);
      send_req(TYPE_FIXED, 32'hFFFF_FFFF, 6'd32, 1'b0);
      send_req(TYPE_FIXED, 32'h0000_0000, 6'd32, 1'b1);
      send_req(TYPE_FIXED, 32'hA5C3_5A3C, 6'd63, 1'b1);
      send_req(TYPE_FIXED, 32'h0000_0001, 6'd1, 1'b0);
      send_req(TYPE_UE, 32'hFFFF_FFFF, 6'd0, 1'b0);
      send_req(TYPE_UE, 32'h0000_0000, 6'd63, 1'b1);
      send_req(TYPE_UE, 32'h0000_0001, 6'd0, 1'b0);
      send_req(TYPE_UE, 32'h0000_0002, 6'd0, 1'b0);
      send_req(TYPE_SE, 32'h0000_0000, 6'd0, 1'b0);
      send_req(TYPE_SE, 32'h0000_0001, 6'd0, 1'b0);
      send_req(TYPE_SE, 32'hFFFF_FFFF, 6'd0, 1'b0);
      send_req(TYPE_SE, 32'h7FFF_FFFF, 6'd0, 1'b0);
      send_req(TYPE_SE, 32'h8000_0000, 6'd0, 1'b0);
      send_req(TYPE_SE, 32'h8000_0001, 6'd0, 1'b0);
      send_req(TYPE_ALIGN, 32'h0000_0000, 6'd0, 1'b1);
      send_req(TYPE_ALIGN, 32'hFFFF_FFFF, 6'd63, 1'b0);
      send_req(TYPE_FIXED, 32'h0000_0005, 6'd3, 1'b0);
      send_req(TYPE_ALIGN, 32'h0000_0000, 6'd0, 1'b0);
      send_req(TYPE_TRAIL, 32'h0000_0000, 6'd0, 1'b0);
      send_req(TYPE_FIXED, 32'h0000_001F, 6'd5, 1'b0);
      send_req(TYPE_TRAIL, 32'hFFFF_FFFF, 6'd63, 1'b1);
      send_req(3'd5, $urandom, 6'( $urandom_range(0, 63)), 1'b1);
      send_req(3'd6, $urandom, 6'( $urandom_range(0, 63)), 1'b0);
      send_req(3'd7, 32'hFFFF_FFFF, 6'd63, 1'b1);
      wait_drained();

      accepted = 0;
      while (accepted < ITEM_TARGET) begin
         gaps_on = !(accepted >= 30 && accepted < 55);
         stalls_on = gaps_on;
         r = $urandom_range(0, 99);
         n = 6'($urandom_range(0, 63));
         if (r < 30) begin
            code_sel = TYPE_FIXED;
            n = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(33, 63))
                                            : 6'($urandom_range(0, 32));
         end else if (r < 40) begin
            code_sel = TYPE_FIXED;
            n = 6'($urandom_range(1, 7));
         end else if (r < 58) begin
            code_sel = TYPE_UE;
         end else if (r < 76) begin
            code_sel = TYPE_SE;
         end else if (r < 85) begin
            code_sel = TYPE_ALIGN;
         end else if (r < 94) begin
            code_sel = TYPE_TRAIL;
         end else begin
            code_sel = 3'($urandom_range(5, 7));
         end
         send_req(code_sel, pick_value(), n, 1'($urandom_range(0, 1)));
         if (code_sel <= TYPE_TRAIL) begin
            accepted++;
         end
         if ($urandom_range(0, 29) == 0) begin
            wait_drained();
         end
      end

      wait_drained();
      @(negedge clock);
      if (fail_count == 0 && bytes_pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
